### sv/mdrc_pkg.sv
// ----------------------------------------------------------------------------
// mdrc_pkg
// shared types, codes and helpers for the motor direction ramp controller
// ----------------------------------------------------------------------------
package mdrc_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // operation codes
    localparam logic [2:0] OP_TOGGLE   = 3'd0;
    localparam logic [2:0] OP_SET_MODE = 3'd1;
    localparam logic [2:0] OP_REARM    = 3'd2;
    localparam logic [2:0] OP_AUTO_SP  = 3'd3;
    localparam logic [2:0] OP_MAN_SP   = 3'd4;
    localparam logic [2:0] OP_TICK     = 3'd5;

    // mode codes, other values are carried but have no special meaning
    localparam logic [2:0] MODE_FAULT    = 3'd0;
    localparam logic [2:0] MODE_RUN_AUTO = 3'd1;
    localparam logic [2:0] MODE_FWD_FRC  = 3'd2;
    localparam logic [2:0] MODE_REV_FRC  = 3'd3;

    // register indexes
    localparam logic [2:0] REG_SETPOINT_MIN   = 3'd0;
    localparam logic [2:0] REG_SETPOINT_MAX   = 3'd1;
    localparam logic [2:0] REG_OUT_MIN        = 3'd2;
    localparam logic [2:0] REG_OUT_MAX        = 3'd3;
    localparam logic [2:0] REG_RAMP_PERIOD    = 3'd4;
    localparam logic [2:0] REG_RAMP_DISABLED  = 3'd5;
    localparam logic [2:0] REG_TWO_DIRECTIONS = 3'd6;

    typedef struct packed {
        logic [7:0]  setpoint_min;
        logic [7:0]  setpoint_max;
        logic [7:0]  out_min;
        logic [7:0]  out_max;
        logic [15:0] ramp_period;
        logic        ramp_disabled;
        logic        two_directions;
    } t_cfg;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] mode_value;
        logic       rearm_condition;
        logic [7:0] setpoint_value;
        logic [7:0] target_setpoint;
    } t_in_item;

    typedef struct packed {
        logic       fwd_command;
        logic       rev_command;
        logic       fwd_contactor;
        logic       rev_contactor;
        logic [7:0] actual_out;
        logic       target_reached;
        logic [2:0] mode_out;
        logic [7:0] auto_out;
        logic [7:0] manual_out;
        logic       healthy;
    } t_res;

    // with crossed limits, a value below lo gives lo and any other gives hi
    function automatic logic [7:0] clamp8(
        input logic [7:0] v,
        input logic [7:0] lo,
        input logic [7:0] hi
    );
        logic [7:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### sv/mdrc_if.sv
// ----------------------------------------------------------------------------
// mdrc channel interfaces
// valid/ready channels for command requests and result requests
// ----------------------------------------------------------------------------
interface mdrc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [2:0] mode_value;
    logic       rearm_condition;
    logic [7:0] setpoint_value;
    logic [7:0] target_setpoint;

    modport source (
        output valid, opcode, mode_value, rearm_condition, setpoint_value,
               target_setpoint,
        input  ready
    );
    modport sink (
        input  valid, opcode, mode_value, rearm_condition, setpoint_value,
               target_setpoint,
        output ready
    );
endinterface

interface mdrc_out_if;
    logic       valid;
    logic       ready;
    logic       fwd_command;
    logic       rev_command;
    logic       fwd_contactor;
    logic       rev_contactor;
    logic [7:0] actual_out;
    logic       target_reached;
    logic [2:0] mode_out;
    logic [7:0] auto_out;
    logic [7:0] manual_out;
    logic       healthy;

    modport source (
        output valid, fwd_command, rev_command, fwd_contactor, rev_contactor,
               actual_out, target_reached, mode_out, auto_out, manual_out,
               healthy,
        input  ready
    );
    modport sink (
        input  valid, fwd_command, rev_command, fwd_contactor, rev_contactor,
               actual_out, target_reached, mode_out, auto_out, manual_out,
               healthy,
        output ready
    );
endinterface

### sv/mdrc_apb_regs.sv
// ----------------------------------------------------------------------------
// mdrc_apb_regs
// apb configuration register file
// ----------------------------------------------------------------------------
module mdrc_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mdrc_pkg::ADDR_W-1:0] paddr,
    input  logic [mdrc_pkg::DATA_W-1:0] pwdata,
    output logic [mdrc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output mdrc_pkg::t_cfg              o_cfg
);
    import mdrc_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint_min   <= 8'd0;
            r_cfg.setpoint_max   <= 8'd255;
            r_cfg.out_min        <= 8'd0;
            r_cfg.out_max        <= 8'd255;
            r_cfg.ramp_period    <= 16'd10;
            r_cfg.ramp_disabled  <= 1'b0;
            r_cfg.two_directions <= 1'b1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SETPOINT_MIN:   r_cfg.setpoint_min   <= pwdata[7:0];
                REG_SETPOINT_MAX:   r_cfg.setpoint_max   <= pwdata[7:0];
                REG_OUT_MIN:        r_cfg.out_min        <= pwdata[7:0];
                REG_OUT_MAX:        r_cfg.out_max        <= pwdata[7:0];
                REG_RAMP_PERIOD:    r_cfg.ramp_period    <= pwdata[15:0];
                REG_RAMP_DISABLED:  r_cfg.ramp_disabled  <= pwdata[0];
                REG_TWO_DIRECTIONS: r_cfg.two_directions <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_SETPOINT_MIN:   prdata[7:0]  = r_cfg.setpoint_min;
            REG_SETPOINT_MAX:   prdata[7:0]  = r_cfg.setpoint_max;
            REG_OUT_MIN:        prdata[7:0]  = r_cfg.out_min;
            REG_OUT_MAX:        prdata[7:0]  = r_cfg.out_max;
            REG_RAMP_PERIOD:    prdata[15:0] = r_cfg.ramp_period;
            REG_RAMP_DISABLED:  prdata[0]    = r_cfg.ramp_disabled;
            REG_TWO_DIRECTIONS: prdata[0]    = r_cfg.two_directions;
            default:            prdata       = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### sv/mdrc_exec.sv
// ----------------------------------------------------------------------------
// mdrc_exec
// controller state and single-pass update for one request
// ----------------------------------------------------------------------------
module mdrc_exec (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_exec,
    input  mdrc_pkg::t_in_item i_item,
    input  mdrc_pkg::t_cfg     i_cfg,
    output mdrc_pkg::t_res     o_res
);
    import mdrc_pkg::*;

    logic        r_cmd_fwd, r_cmd_rev, r_next_rev;
    logic        r_latch_fwd, r_latch_rev, r_reached;
    logic [2:0]  r_mode, r_saved_mode;
    logic [7:0]  r_auto_sp, r_man_sp, r_actual;
    logic [15:0] r_elapsed;

    logic        n_cmd_fwd, n_cmd_rev, n_next_rev;
    logic        n_latch_fwd, n_latch_rev, n_reached;
    logic [2:0]  n_mode, n_saved_mode;
    logic [7:0]  n_auto_sp, n_man_sp, n_actual;
    logic [15:0] n_elapsed;

    logic [7:0]  ramp_base;
    logic [15:0] el_inc;
    logic        above;

    always_comb begin
        n_cmd_fwd    = r_cmd_fwd;
        n_cmd_rev    = r_cmd_rev;
        n_next_rev   = r_next_rev;
        n_latch_fwd  = r_latch_fwd;
        n_latch_rev  = r_latch_rev;
        n_reached    = r_reached;
        n_mode       = r_mode;
        n_saved_mode = r_saved_mode;
        n_auto_sp    = r_auto_sp;
        n_man_sp     = r_man_sp;
        n_actual     = r_actual;
        n_elapsed    = r_elapsed;

        // tick path, worked out every cycle and used only on a tick
        ramp_base = i_cfg.ramp_disabled ? i_item.target_setpoint : r_actual;
        el_inc    = (r_elapsed != 16'hFFFF) ? r_elapsed + 16'd1 : r_elapsed;

        case (i_item.opcode)
            OP_TOGGLE: begin
                if (!r_cmd_fwd && !r_cmd_rev) begin
                    n_cmd_fwd = !r_next_rev;
                    n_cmd_rev = r_next_rev;
                end else if (r_cmd_fwd != r_cmd_rev) begin
                    n_cmd_fwd  = 1'b0;
                    n_cmd_rev  = 1'b0;
                    n_next_rev = !r_next_rev && i_cfg.two_directions;
                end
            end
            OP_SET_MODE: begin
                if (r_mode != i_item.mode_value && r_mode != MODE_FAULT) begin
                    n_saved_mode = r_mode;
                    n_mode       = i_item.mode_value;
                end
            end
            OP_REARM: begin
                if (r_mode == MODE_FAULT && i_item.rearm_condition) begin
                    n_mode = r_saved_mode;
                end
            end
            OP_AUTO_SP: begin
                n_auto_sp = clamp8(i_item.setpoint_value, i_cfg.setpoint_min,
                                   i_cfg.setpoint_max);
            end
            OP_MAN_SP: begin
                n_man_sp = clamp8(i_item.setpoint_value, i_cfg.out_min, i_cfg.out_max);
            end
            OP_TICK: begin
                n_actual  = ramp_base;
                n_reached = (ramp_base == i_item.target_setpoint);
                if (n_reached) begin
                    n_elapsed = 16'd0;
                end else if (el_inc >= i_cfg.ramp_period) begin
                    n_elapsed = 16'd0;
                    n_actual  = (i_item.target_setpoint > ramp_base) ?
                                ramp_base + 8'd1 : ramp_base - 8'd1;
                end else begin
                    n_elapsed = el_inc;
                end
            end
            default: ;
        endcase

        // contactor latches follow the ramped value
        above = n_actual > i_cfg.setpoint_min;
        if (i_item.opcode == OP_TICK) begin
            n_latch_fwd = (above && ((r_mode == MODE_RUN_AUTO && r_cmd_fwd) || r_latch_fwd))
                          || r_mode == MODE_FWD_FRC;
            n_latch_rev = (above && ((r_mode == MODE_RUN_AUTO && r_cmd_rev) || r_latch_rev))
                          || r_mode == MODE_REV_FRC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_fwd    <= 1'b0;
            r_cmd_rev    <= 1'b0;
            r_next_rev   <= 1'b0;
            r_latch_fwd  <= 1'b0;
            r_latch_rev  <= 1'b0;
            r_reached    <= 1'b0;
            r_mode       <= MODE_RUN_AUTO;
            r_saved_mode <= MODE_RUN_AUTO;
            r_auto_sp    <= 8'd0;
            r_man_sp     <= 8'd0;
            r_actual     <= 8'd0;
            r_elapsed    <= 16'd0;
        end else if (i_exec) begin
            r_cmd_fwd    <= n_cmd_fwd;
            r_cmd_rev    <= n_cmd_rev;
            r_next_rev   <= n_next_rev;
            r_latch_fwd  <= n_latch_fwd;
            r_latch_rev  <= n_latch_rev;
            r_reached    <= n_reached;
            r_mode       <= n_mode;
            r_saved_mode <= n_saved_mode;
            r_auto_sp    <= n_auto_sp;
            r_man_sp     <= n_man_sp;
            r_actual     <= n_actual;
            r_elapsed    <= n_elapsed;
        end
    end

    // result shows the state after this request
    always_comb begin
        o_res.fwd_command    = n_cmd_fwd;
        o_res.rev_command    = n_cmd_rev;
        o_res.fwd_contactor  = n_latch_fwd;
        o_res.rev_contactor  = n_latch_rev;
        o_res.actual_out     = n_actual;
        o_res.target_reached = n_reached;
        o_res.mode_out       = n_mode;
        o_res.auto_out       = n_auto_sp;
        o_res.manual_out     = n_man_sp;
        o_res.healthy        = (n_mode != MODE_FAULT);
    end

`ifndef SYNTHESIS
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_cmd_fwd && r_cmd_rev))
        else $error("both direction commands set");

    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_FAULT && !(i_exec && i_item.opcode == OP_REARM))
        |=> r_mode == MODE_FAULT)
        else $error("fault left without rearm");

    a_reached_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_exec && i_item.opcode == OP_TICK && n_reached)
        |=> (r_elapsed == 16'd0 && r_reached))
        else $error("tick counter not cleared on reaching target");

    a_actual_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_exec && i_item.opcode == OP_TICK) |=> $stable(r_actual))
        else $error("actual setpoint moved outside a tick");
`endif

endmodule

### sv/motor_direction_ramp_controller_unit.sv
// ----------------------------------------------------------------------------
// motor_direction_ramp_controller_unit
// motor direction toggle, mode, setpoint clamp and ramp/contactor controller
// ----------------------------------------------------------------------------
//  channel   | dir | handshake         | carries
//  ----------+-----+-------------------+--------------------------------------
//  i_cmd     | in  | valid/ready       | opcode, mode, rearm, setpoint, target
//  o_res     | out | valid/ready       | commands, contactors, setpoints, mode
//  apb       | in  | psel/penable      | seven configuration registers
//
//  one request per cycle sustained while o_res is ready; a request is held
//  in the input register, where the state update runs, then moves into the
//  result register and leaves from there; the input register refills while a
//  finished result waits, so o_res stalls back up into i_cmd only when both
//  registers are full
//  synchronous active-low reset returns state and valid flags to defaults
// ----------------------------------------------------------------------------
module motor_direction_ramp_controller_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mdrc_in_if.sink                     i_cmd,
    mdrc_out_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mdrc_pkg::ADDR_W-1:0] paddr,
    input  logic [mdrc_pkg::DATA_W-1:0] pwdata,
    output logic [mdrc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import mdrc_pkg::*;

    t_cfg     cfg;
    t_in_item r_in;
    logic     r_in_valid;
    t_res     r_out;
    logic     r_out_valid;
    t_res     exec_res;
    logic     advance;
    logic     in_take;

    // configuration registers
    mdrc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // request moves from the input register into the result register
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign in_take     = i_cmd.valid && i_cmd.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.opcode          <= i_cmd.opcode;
            r_in.mode_value      <= i_cmd.mode_value;
            r_in.rearm_condition <= i_cmd.rearm_condition;
            r_in.setpoint_value  <= i_cmd.setpoint_value;
            r_in.target_setpoint <= i_cmd.target_setpoint;
        end
    end

    // state update, committed when the request advances
    mdrc_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exec  (advance),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (exec_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= exec_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.fwd_command    = r_out.fwd_command;
    assign o_res.rev_command    = r_out.rev_command;
    assign o_res.fwd_contactor  = r_out.fwd_contactor;
    assign o_res.rev_contactor  = r_out.rev_contactor;
    assign o_res.actual_out     = r_out.actual_out;
    assign o_res.target_reached = r_out.target_reached;
    assign o_res.mode_out       = r_out.mode_out;
    assign o_res.auto_out       = r_out.auto_out;
    assign o_res.manual_out     = r_out.manual_out;
    assign o_res.healthy        = r_out.healthy;

endmodule
